@@ hw/rtl/kcv_pkg.sv @@
// ----------------------------------------------------------------------------
// kcv_pkg
// Shared types, codes and fixed-point helpers for the constant-velocity
// Kalman tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package kcv_pkg;

  typedef enum logic [1:0] {
    FN_LOAD     = 2'd0,
    FN_INTERVAL = 2'd1,
    FN_PREDICT  = 2'd2,
    FN_UPDATE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_MEAS_NOISE = 2'd0,
    REG_PROC_POS   = 2'd1,
    REG_PROC_VEL   = 2'd2
  } reg_idx_e;

  localparam int unsigned WideW = 80;
  localparam int unsigned MulAW = 42;
  localparam int unsigned MulBW = 33;
  localparam int unsigned ProdW = MulAW + MulBW;

  typedef logic signed [WideW-1:0] wide_t;

  localparam logic signed [31:0] OneQ16 = 32'sd65536;

  function automatic wide_t rnd(input wide_t x);
    wide_t y;
    y = x + wide_t'(32768);
    return y >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t x);
    logic signed [31:0] r;
    if (x > wide_t'(32'sh7fffffff)) begin
      r = 32'sh7fffffff;
    end else if (x < wide_t'(-33'sh080000000)) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/kcv_mul.sv @@
// ----------------------------------------------------------------------------
// kcv_mul
// Shared signed multiplier, 42 by 33 bits, built from one 26 by 33 bit
// multiplier used first for the low and then for the high half.
// ----------------------------------------------------------------------------
`default_nettype none

module kcv_mul (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire logic signed [kcv_pkg::MulAW-1:0] a_i,
  input  wire logic signed [kcv_pkg::MulBW-1:0] b_i,
  output logic                             done_o,
  output logic signed [kcv_pkg::ProdW-1:0] prod_o
);
  import kcv_pkg::*;

  logic signed [MulAW-1:0]   a_q;
  logic signed [MulBW-1:0]   b_q;
  logic                      busy_q, phase_q, done_q;
  logic signed [58:0]        plo_q;
  logic signed [ProdW-1:0]   prod_q;
  logic        [25:0]        op;
  logic signed [58:0]        m;

  assign op = phase_q ? a_q[MulAW-1:16] : {10'b0, a_q[15:0]};
  assign m  = $signed(op) * b_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (busy_q && !phase_q) begin
      plo_q <= m;
    end
    if (busy_q && phase_q) begin
      prod_q <= $signed({m, 16'b0}) + ProdW'(plo_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= busy_q && phase_q;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
      end else if (busy_q) begin
        phase_q <= !phase_q;
        if (phase_q) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

@@ hw/rtl/kcv_div.sv @@
// ----------------------------------------------------------------------------
// kcv_div
// Radix-2 restoring divider for the Kalman gain: a 48 bit signed dividend
// over a 34 bit signed divisor, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module kcv_div (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire logic signed [47:0] num_i,
  input  wire logic signed [33:0] den_i,
  output logic                    done_o,
  output logic signed [31:0]      quot_o
);
  import kcv_pkg::*;

  logic [47:0]        nmag_q, quot_q;
  logic [33:0]        dmag_q;
  logic [34:0]        rem_q;
  logic               neg_q, busy_q, fin_q, done_q;
  logic [5:0]         cnt_q;
  logic signed [31:0] res_q;
  logic [34:0]        rem_sh;
  logic               ge;
  logic [47:0]        quot_nx;

  assign rem_sh  = {rem_q[33:0], nmag_q[47]};
  assign ge      = rem_sh >= {1'b0, dmag_q};
  assign quot_nx = {quot_q[46:0], ge};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nmag_q <= num_i[47] ? 48'(-num_i) : num_i;
      dmag_q <= den_i[33] ? 34'(-den_i) : den_i;
      neg_q  <= num_i[47] ^ den_i[33];
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      nmag_q <= {nmag_q[46:0], 1'b0};
      rem_q  <= ge ? rem_sh - {1'b0, dmag_q} : rem_sh;
      quot_q <= quot_nx;
    end
    if (fin_q) begin
      if (neg_q) begin
        res_q <= (quot_q > 48'h80000000) ? 32'sh80000000 : 32'(-quot_q);
      end else begin
        res_q <= (quot_q > 48'h7fffffff) ? 32'sh7fffffff : quot_q[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd47) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/kalman_cv_tracker_1d.sv @@
// Sequencing: load and set interval go straight to the output state, a predict makes four
// passes through the shared multiplier, an update two gain divisions and six such passes.
// Throughput: one item at a time; the next item is taken once the current one is in the
// output register. Reset clears the state to zero, the covariance to identity and the
// noise registers to their defaults.
// ----------------------------------------------------------------------------
// kalman_cv_tracker_1d
// Two-state constant-velocity Kalman filter in Q16.16, sequenced over one
// shared multiplier and one iterative divider.
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_cv_tracker_1d (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     psel,
  input  wire                     penable,
  input  wire                     pwrite,
  input  wire        [3:0]        paddr,
  input  wire        [31:0]       pwdata,
  output logic       [31:0]       prdata,
  output logic                    pready,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire        [1:0]        func_i,
  input  wire        [23:0]       interval_i,
  input  wire logic signed [31:0] init_pos_i,
  input  wire logic signed [31:0] init_vel_i,
  input  wire logic signed [31:0] measured_pos_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output logic signed [31:0]      pos_est_o,
  output logic signed [31:0]      vel_est_o,
  output logic                    div_fault_o
);
  import kcv_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MISS  = 5'b00010,
    ST_MWAIT = 5'b00100,
    ST_DWAIT = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [23:0] meas_noise_q, proc_pos_q, proc_vel_q, d_q;
  logic signed [31:0] post_pos_q, post_vel_q, prior_pos_q, prior_vel_q;
  logic signed [31:0] p00_q, p01_q, p10_q, p11_q, k0_q, k1_q, e_q;
  logic signed [MulAW-1:0] t0_q, t1_q;
  logic [2:0]  step_q;
  func_e       func_q;
  logic        fault_q, out_valid_q, out_fault_q;
  logic signed [31:0] out_pos_q, out_vel_q;

  logic        accept, cfg_wr;
  wide_t       s_wide, r;
  logic        mul_start, mul_done, div_start, div_done, last_step;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_prod;
  logic signed [47:0] div_num;
  logic signed [31:0] div_quot;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign s_wide     = wide_t'(p00_q) + wide_t'(meas_noise_q);
  assign r          = rnd(wide_t'(mul_prod));
  assign last_step  = (func_q == FN_PREDICT) ? (step_q == 3'd3) : (step_q == 3'd5);

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_MEAS_NOISE: prdata = {8'b0, meas_noise_q};
      REG_PROC_POS:   prdata = {8'b0, proc_pos_q};
      REG_PROC_VEL:   prdata = {8'b0, proc_vel_q};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    mul_a = MulAW'(k0_q);
    mul_b = MulBW'(e_q);
    if (func_q == FN_PREDICT) begin
      mul_b = MulBW'({1'b0, d_q});
      unique case (step_q)
        3'd0:    mul_a = MulAW'(post_vel_q);
        3'd1:    mul_a = MulAW'(p10_q);
        3'd2:    mul_a = MulAW'(p11_q);
        default: mul_a = t1_q;
      endcase
    end else begin
      unique case (step_q)
        3'd0:    begin mul_a = MulAW'(k0_q); mul_b = MulBW'(e_q);   end
        3'd1:    begin mul_a = MulAW'(k1_q); mul_b = MulBW'(e_q);   end
        3'd2:    begin mul_a = MulAW'(k1_q); mul_b = MulBW'(p00_q); end
        3'd3:    begin mul_a = MulAW'(k1_q); mul_b = MulBW'(p01_q); end
        3'd4:    begin mul_a = MulAW'(k0_q); mul_b = MulBW'(p00_q); end
        default: begin mul_a = MulAW'(k0_q); mul_b = MulBW'(p01_q); end
      endcase
    end
  end

  assign mul_start = state_q == ST_MISS;

  always_comb begin
    div_start = 1'b0;
    div_num   = {p00_q, 16'b0};
    if (accept && func_e'(func_i) == FN_UPDATE && s_wide != '0) begin
      div_start = 1'b1;
    end else if (state_q == ST_DWAIT && div_done && step_q == 3'd0) begin
      div_start = 1'b1;
      div_num   = {p10_q, 16'b0};
    end
  end

  kcv_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  kcv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (s_wide[33:0]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_e'(func_i))
            FN_PREDICT: state_d = ST_MISS;
            FN_UPDATE:  state_d = (s_wide == '0) ? ST_OUT : ST_DWAIT;
            default:    state_d = ST_OUT;
          endcase
        end
      end
      ST_MISS:  state_d = ST_MWAIT;
      ST_MWAIT: if (mul_done) state_d = last_step ? ST_OUT : ST_MISS;
      ST_DWAIT: if (div_done && step_q == 3'd1) state_d = ST_MISS;
      ST_OUT:   if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      meas_noise_q <= 24'd32768;
      proc_pos_q   <= 24'd65536;
      proc_vel_q   <= 24'd65536;
      d_q          <= '0;
      post_pos_q   <= '0;
      post_vel_q   <= '0;
      prior_pos_q  <= '0;
      prior_vel_q  <= '0;
      p00_q        <= OneQ16;
      p01_q        <= '0;
      p10_q        <= '0;
      p11_q        <= OneQ16;
      step_q       <= '0;
      func_q       <= FN_LOAD;
      fault_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        unique case (reg_idx_e'(paddr[3:2]))
          REG_MEAS_NOISE: meas_noise_q <= pwdata[23:0];
          REG_PROC_POS:   proc_pos_q   <= pwdata[23:0];
          REG_PROC_VEL:   proc_vel_q   <= pwdata[23:0];
          default:        ;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        func_q  <= func_e'(func_i);
        step_q  <= '0;
        fault_q <= 1'b0;
        unique case (func_e'(func_i))
          FN_LOAD: begin
            post_pos_q <= init_pos_i;
            post_vel_q <= init_vel_i;
          end
          FN_INTERVAL: d_q <= interval_i;
          FN_UPDATE:   fault_q <= s_wide == '0;
          default:     ;
        endcase
      end
      if (state_q == ST_DWAIT && div_done) begin
        step_q <= (step_q == 3'd0) ? 3'd1 : 3'd0;
      end
      if (state_q == ST_MWAIT && mul_done) begin
        step_q <= step_q + 3'd1;
        if (func_q == FN_PREDICT) begin
          unique case (step_q)
            3'd0: begin
              prior_pos_q <= sat32(wide_t'(post_pos_q) + r);
              post_pos_q  <= sat32(wide_t'(post_pos_q) + r);
              prior_vel_q <= post_vel_q;
            end
            3'd1: ;
            3'd2: p10_q <= sat32(wide_t'(p10_q) + r);
            default: begin
              p00_q <= sat32(wide_t'(t0_q) + r + wide_t'(proc_pos_q));
              p01_q <= sat32(wide_t'(t1_q));
              p11_q <= sat32(wide_t'(p11_q) + wide_t'(proc_vel_q));
            end
          endcase
        end else begin
          unique case (step_q)
            3'd0:    post_pos_q <= sat32(wide_t'(prior_pos_q) + r);
            3'd1:    post_vel_q <= sat32(wide_t'(prior_vel_q) + r);
            3'd2:    p10_q <= sat32(wide_t'(p10_q) - r);
            3'd3:    p11_q <= sat32(wide_t'(p11_q) - r);
            3'd4:    p00_q <= sat32(wide_t'(p00_q) - r);
            default: p01_q <= sat32(wide_t'(p01_q) - r);
          endcase
        end
      end
      if (state_q == ST_OUT && state_d == ST_IDLE) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      e_q <= sat32(wide_t'(measured_pos_i) - wide_t'(prior_pos_q));
    end
    if (state_q == ST_DWAIT && div_done) begin
      if (step_q == 3'd0) begin
        k0_q <= div_quot;
      end else begin
        k1_q <= div_quot;
      end
    end
    if (state_q == ST_MWAIT && mul_done && func_q == FN_PREDICT) begin
      if (step_q == 3'd1) begin
        t0_q <= MulAW'(wide_t'(p00_q) + r);
      end
      if (step_q == 3'd2) begin
        t1_q <= MulAW'(wide_t'(p01_q) + r);
      end
    end
    if (state_q == ST_OUT && state_d == ST_IDLE) begin
      out_pos_q   <= post_pos_q;
      out_vel_q   <= post_vel_q;
      out_fault_q <= fault_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_est_o   = out_pos_q;
  assign vel_est_o   = out_vel_q;
  assign div_fault_o = out_fault_q;

endmodule

`default_nettype wire

@@ test/tb_kalman_cv_tracker_1d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kalman_cv_tracker_1d
// Self-checking bench for the constant-velocity Kalman tracker. A queue of
// items feeds a clocked driver, a clocked monitor compares every result with
// an in-bench fixed-point filter, and the noise registers are rewritten over
// APB between phases.
// ----------------------------------------------------------------------------
module tb_kalman_cv_tracker_1d;
  import kcv_pkg::*;

  localparam int unsigned CycleLimit = 3000000;

  typedef logic signed [127:0] acc_t;

  typedef struct {
    func_e              fn;
    logic [23:0]        dt;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] meas;
  } track_item_t;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               fault;
  } estimate_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  func_e              func_i = FN_LOAD;
  logic [23:0]        interval_i = '0;
  logic signed [31:0] init_pos_i = '0;
  logic signed [31:0] init_vel_i = '0;
  logic signed [31:0] measured_pos_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] pos_est_o;
  logic signed [31:0] vel_est_o;
  logic               div_fault_o;

  track_item_t        pending_q[$];
  estimate_t          estimate_q[$];
  int unsigned        error_count = 0;
  int unsigned        cycle_count = 0;
  bit                 quiet = 1'b0;
  bit                 hold_req = 1'b0;
  bit                 hold_done = 1'b0;
  int unsigned        hold_left = 0;

  logic [23:0]        r_noise = 24'd32768;
  logic [23:0]        q_pos = 24'd65536;
  logic [23:0]        q_vel = 24'd65536;
  logic signed [31:0] post_p = '0;
  logic signed [31:0] post_v = '0;
  logic signed [31:0] prior_p = '0;
  logic signed [31:0] prior_v = '0;
  logic signed [31:0] cov[4] = '{32'sd65536, 32'sd0, 32'sd0, 32'sd65536};
  logic [23:0]        frame_dt = '0;

  kalman_cv_tracker_1d u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .func_i(func_i),
    .interval_i(interval_i), .init_pos_i(init_pos_i), .init_vel_i(init_vel_i),
    .measured_pos_i(measured_pos_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .pos_est_o(pos_est_o), .vel_est_o(vel_est_o), .div_fault_o(div_fault_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic acc_t round_q16(input acc_t x);
    return (x + acc_t'(32768)) >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp32(input acc_t x);
    if (x > acc_t'(32'sh7fffffff)) begin
      return 32'sh7fffffff;
    end else if (x < -acc_t'(64'sh80000000)) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  task automatic filter_step(input track_item_t it);
    acc_t       d, p00, p01, p10, p11, t0, t1, s, k0, k1, e;
    estimate_t  est;
    d = {104'd0, frame_dt};
    p00 = cov[0];
    p01 = cov[1];
    p10 = cov[2];
    p11 = cov[3];
    est.fault = 1'b0;
    case (it.fn)
      FN_LOAD: begin
        post_p = it.pos;
        post_v = it.vel;
      end
      FN_INTERVAL: begin
        frame_dt = it.dt;
      end
      FN_PREDICT: begin
        prior_p = clamp32(acc_t'(post_p) + round_q16(d * acc_t'(post_v)));
        prior_v = post_v;
        t0 = p00 + round_q16(d * p10);
        t1 = p01 + round_q16(d * p11);
        cov[0] = clamp32(t0 + round_q16(d * t1) + acc_t'({104'd0, q_pos}));
        cov[1] = clamp32(t1);
        cov[2] = clamp32(p10 + round_q16(d * p11));
        cov[3] = clamp32(p11 + acc_t'({104'd0, q_vel}));
        post_p = prior_p;
        post_v = prior_v;
      end
      default: begin
        s = p00 + acc_t'({104'd0, r_noise});
        if (s == 0) begin
          est.fault = 1'b1;
        end else begin
          k0 = clamp32((p00 * 65536) / s);
          k1 = clamp32((p10 * 65536) / s);
          e = clamp32(acc_t'(it.meas) - acc_t'(prior_p));
          post_p = clamp32(acc_t'(prior_p) + round_q16(k0 * e));
          post_v = clamp32(acc_t'(prior_v) + round_q16(k1 * e));
          cov[0] = clamp32(p00 - round_q16(k0 * p00));
          cov[1] = clamp32(p01 - round_q16(k0 * p01));
          cov[2] = clamp32(p10 - round_q16(k1 * p00));
          cov[3] = clamp32(p11 - round_q16(k1 * p01));
        end
      end
    endcase
    est.pos = post_p;
    est.vel = post_v;
    estimate_q.push_back(est);
  endtask

  always @(posedge clk_i) begin : driver
    track_item_t it;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        it.fn = func_i;
        it.dt = interval_i;
        it.pos = init_pos_i;
        it.vel = init_vel_i;
        it.meas = measured_pos_i;
        filter_step(it);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 25)) begin
          it = pending_q.pop_front();
          in_valid_i <= 1'b1;
          func_i <= it.fn;
          interval_i <= it.dt;
          init_pos_i <= it.pos;
          init_vel_i <= it.vel;
          measured_pos_i <= it.meas;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    estimate_t est;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (estimate_q.size() == 0) begin
          $error("result with no item pending: pos %0d vel %0d", pos_est_o, vel_est_o);
          error_count++;
        end else begin
          est = estimate_q.pop_front();
          if (pos_est_o !== est.pos) begin
            $error("pos_est expected %0d actual %0d", est.pos, pos_est_o);
            error_count++;
          end
          if (vel_est_o !== est.vel) begin
            $error("vel_est expected %0d actual %0d", est.vel, vel_est_o);
            error_count++;
          end
          if (div_fault_o !== est.fault) begin
            $error("div_fault expected %0b actual %0b", est.fault, div_fault_o);
            error_count++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= 600;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 25);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic reg_write(input reg_idx_e idx, input logic [23:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {8'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MEAS_NOISE: r_noise = value;
      REG_PROC_POS:   q_pos = value;
      REG_PROC_VEL:   q_vel = value;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid_i || estimate_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
  endtask

  function automatic track_item_t make_item(input func_e fn, input logic [23:0] dt,
                                            input logic signed [31:0] pos,
                                            input logic signed [31:0] vel,
                                            input logic signed [31:0] meas);
    track_item_t it;
    it.fn = fn;
    it.dt = dt;
    it.pos = pos;
    it.vel = vel;
    it.meas = meas;
    return it;
  endfunction

  function automatic logic [31:0] pick_value(input int unsigned span);
    if ($urandom_range(9) == 0) begin
      return $urandom();
    end
    return $urandom_range(2 * span) - span;
  endfunction

  task automatic random_track(input int unsigned count);
    track_item_t it;
    int unsigned roll;
    logic [31:0] truth;
    truth = pick_value(32'h0040_0000);
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      it = make_item(FN_PREDICT, 24'($urandom()), $urandom(), $urandom(), $urandom());
      if (roll < 8) begin
        it.fn = FN_LOAD;
        it.pos = pick_value(32'h0040_0000);
        it.vel = pick_value(32'h0004_0000);
      end else if (roll < 16) begin
        it.fn = FN_INTERVAL;
        it.dt = ($urandom_range(7) == 0) ? 24'($urandom()) : 24'($urandom_range(24'h8000));
      end else if (roll < 55) begin
        it.fn = FN_PREDICT;
      end else begin
        it.fn = FN_UPDATE;
        it.meas = ($urandom_range(9) == 0) ? 32'($urandom())
                                           : truth + $urandom_range(32'h20000) - 32'h10000;
      end
      pending_q.push_back(it);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    pending_q.push_back(make_item(FN_UPDATE, 0, 0, 0, 32'sh00010000));
    pending_q.push_back(make_item(FN_LOAD, 0, 32'sh7fffffff, 32'sh80000000, 0));
    pending_q.push_back(make_item(FN_PREDICT, 0, 0, 0, 0));
    pending_q.push_back(make_item(FN_INTERVAL, 24'hffffff, 0, 0, 0));
    pending_q.push_back(make_item(FN_PREDICT, 0, 0, 0, 0));
    pending_q.push_back(make_item(FN_UPDATE, 0, 0, 0, 32'sh80000000));
    pending_q.push_back(make_item(FN_UPDATE, 0, 0, 0, 32'sh7fffffff));
    pending_q.push_back(make_item(FN_LOAD, 0, 32'sh80000000, 32'sh7fffffff, 0));
    pending_q.push_back(make_item(FN_PREDICT, 0, 0, 0, 0));
    pending_q.push_back(make_item(FN_INTERVAL, 24'h000000, 0, 0, 0));
    pending_q.push_back(make_item(FN_PREDICT, 0, 0, 0, 0));
    pending_q.push_back(make_item(FN_UPDATE, 0, 0, 0, 0));
    wait_drained();

    reg_write(REG_MEAS_NOISE, 24'd0);
    reg_write(REG_PROC_POS, 24'd0);
    reg_write(REG_PROC_VEL, 24'd0);
    pending_q.push_back(make_item(FN_INTERVAL, 24'h004000, 0, 0, 0));
    pending_q.push_back(make_item(FN_LOAD, 0, 32'sh00050000, 32'sh00010000, 0));
    pending_q.push_back(make_item(FN_PREDICT, 0, 0, 0, 0));
    pending_q.push_back(make_item(FN_UPDATE, 0, 0, 0, 32'sh00060000));
    pending_q.push_back(make_item(FN_UPDATE, 0, 0, 0, 32'sh00070000));
    pending_q.push_back(make_item(FN_UPDATE, 0, 0, 0, 32'sh00080000));
    wait_drained();

    reg_write(REG_MEAS_NOISE, 24'hffffff);
    reg_write(REG_PROC_POS, 24'hffffff);
    reg_write(REG_PROC_VEL, 24'hffffff);
    reg_write(reg_idx_e'(2'd3), 24'h123456);
    random_track(150);
    wait_drained();

    reg_write(REG_MEAS_NOISE, 24'd32768);
    reg_write(REG_PROC_POS, 24'd65536);
    reg_write(REG_PROC_VEL, 24'd65536);
    quiet = 1'b1;
    random_track(150);
    wait_drained();
    quiet = 1'b0;

    hold_req = 1'b1;
    random_track(150);
    wait_drained();

    for (int unsigned ph = 0; ph < 3; ph++) begin
      reg_write(REG_MEAS_NOISE, 24'($urandom_range(24'h40000)));
      reg_write(REG_PROC_POS, 24'($urandom_range(24'h20000)));
      reg_write(REG_PROC_VEL, ($urandom_range(3) == 0) ? 24'($urandom())
                                                       : 24'($urandom_range(24'h8000)));
      random_track(150);
      wait_drained();
    end

    repeat (200) @(posedge clk_i);
    if (error_count == 0 && estimate_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/kcv_pkg.sv
hw/rtl/kcv_mul.sv
hw/rtl/kcv_div.sv
hw/rtl/kalman_cv_tracker_1d.sv
test/tb_kalman_cv_tracker_1d.sv
